[rtl/core/gsp_pkg.sv]
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types and constants of the GSM septet pack/unpack unit.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int unsigned SEPTET_W        = 7;
  localparam int unsigned OCTET_W         = 8;
  localparam int unsigned POS_W           = 3;
  localparam logic [SEPTET_W-1:0] SEPTET_MASK  = 7'h7f;
  localparam logic [POS_W-1:0]    GROUP_OCTETS = 3'd7;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef enum logic {
    MODE_PACK   = 1'b0,
    MODE_UNPACK = 1'b1
  } mode_t;

  // One queued transfer group: the results caused by one accepted item.
  typedef struct packed {
    logic               two;    // second result present
    logic [OCTET_W-1:0] byte0;
    logic [OCTET_W-1:0] byte1;
    logic               last;   // set when the item was marked last
  } gsp_entry_t;

endpackage

[rtl/core/gsp_stream_if.sv]
// ----------------------------------------------------------------------------
// gsp_stream_if
// Valid/ready channels of the septet unit: input, result and config.
// ----------------------------------------------------------------------------
interface gsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface gsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface gsp_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

[rtl/core/gsp_front.sv]
// ----------------------------------------------------------------------------
// gsp_front
// Accepts items, holds mode, group position and carry, and forms the results.
// ----------------------------------------------------------------------------
module gsp_front
  import gsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  gsp_cfg_if.sink      cfg_ch,
  gsp_in_if.sink       in_ch,
  input  logic         q_full,
  output logic         push,
  output gsp_entry_t   push_entry
);

  mode_t                mode_r;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [SEPTET_W-1:0]  carry_r, carry_nxt;

  logic                 accept;
  logic                 has_result;

  // pack path
  logic [SEPTET_W-1:0]  p_char;
  logic [3:0]           p_shamt;
  logic [14:0]          p_wide;
  logic [OCTET_W-1:0]   p_octet;
  logic [SEPTET_W-1:0]  p_carry;
  logic [POS_W-1:0]     p_pos;

  // unpack path
  logic [POS_W-1:0]     u_pos;
  logic [SEPTET_W-1:0]  u_carry_in;
  logic [14:0]          u_wide;
  logic [SEPTET_W-1:0]  u_char;
  logic [OCTET_W-1:0]   u_shr;
  logic [SEPTET_W-1:0]  u_carry;
  logic [POS_W-1:0]     u_pos_inc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && in_ch.ready;

  // Pack: merge the new septet above the carry.
  assign p_char  = in_ch.data_byte[SEPTET_W-1:0] & SEPTET_MASK;
  assign p_shamt = 4'd8 - {1'b0, pos_r};
  assign p_wide  = {8'd0, p_char} << p_shamt;
  assign p_octet = p_wide[OCTET_W-1:0] | {1'b0, carry_r};
  assign p_carry = (pos_r == '0) ? p_char : ((p_char >> pos_r) & SEPTET_MASK);
  assign p_pos   = pos_r + 3'd1;

  // Unpack: a stray position seven restarts the group.
  assign u_pos      = (pos_r == GROUP_OCTETS) ? '0 : pos_r;
  assign u_carry_in = (pos_r == GROUP_OCTETS) ? '0 : carry_r;
  assign u_wide     = {7'd0, in_ch.data_byte} << u_pos;
  assign u_char     = u_wide[SEPTET_W-1:0] | u_carry_in;
  assign u_shr      = in_ch.data_byte >> (GROUP_OCTETS - u_pos);
  assign u_carry    = u_shr[SEPTET_W-1:0] & SEPTET_MASK;
  assign u_pos_inc  = u_pos + 3'd1;

  always_comb begin
    push_entry = '0;
    has_result = 1'b0;
    pos_nxt    = pos_r;
    carry_nxt  = carry_r;
    unique case (mode_r)
      MODE_PACK: begin
        pos_nxt   = p_pos;
        carry_nxt = p_carry;
        if (pos_r != '0) begin
          has_result       = 1'b1;
          push_entry.byte0 = p_octet;
          if (in_ch.last && (p_pos != '0)) begin
            push_entry.two   = 1'b1;
            push_entry.byte1 = {1'b0, p_carry};
          end
        end else if (in_ch.last) begin
          // first septet of a group flushed as its own octet
          has_result       = 1'b1;
          push_entry.byte0 = {1'b0, p_carry};
        end
      end
      MODE_UNPACK: begin
        has_result       = 1'b1;
        push_entry.byte0 = {1'b0, u_char};
        pos_nxt          = u_pos_inc;
        carry_nxt        = u_carry;
        if (u_pos_inc == GROUP_OCTETS) begin
          push_entry.two   = 1'b1;
          push_entry.byte1 = {1'b0, u_carry};
          pos_nxt          = '0;
          carry_nxt        = '0;
        end
      end
      default: ;
    endcase
    push_entry.last = in_ch.last;
    if (in_ch.last) begin
      pos_nxt   = '0;
      carry_nxt = '0;
    end
  end

  assign push = accept && has_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PACK;
      pos_r   <= '0;
      carry_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      mode_r  <= mode_t'(cfg_ch.mode);
      pos_r   <= '0;
      carry_r <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

[rtl/core/gsp_queue.sv]
// ----------------------------------------------------------------------------
// gsp_queue
// Short first-in first-out queue of result groups between front and back.
// ----------------------------------------------------------------------------
module gsp_queue
  import gsp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  gsp_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output gsp_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  gsp_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue pushed while full");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

[rtl/core/gsp_back.sv]
// ----------------------------------------------------------------------------
// gsp_back
// Drains result groups from the queue, one result per output transfer.
// ----------------------------------------------------------------------------
module gsp_back
  import gsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  gsp_entry_t head,
  output logic       pop,
  gsp_out_if.source  out_ch
);

  logic sel_r, sel_nxt;
  logic xfer;
  logic final_res;

  assign final_res       = sel_r || !head.two;
  assign out_ch.valid    = !q_empty;
  assign out_ch.out_byte = sel_r ? head.byte1 : head.byte0;
  assign out_ch.out_last = head.last && final_res;

  assign xfer = out_ch.valid && out_ch.ready;
  assign pop  = xfer && final_res;

  always_comb begin
    sel_nxt = sel_r;
    if (xfer) begin
      sel_nxt = !final_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

[rtl/core/gsm_septet_pack_unpack_unit.sv]
// ----------------------------------------------------------------------------
// gsm_septet_pack_unpack_unit
// GSM 7-bit default alphabet septet packer/unpacker on a byte stream.
// ----------------------------------------------------------------------------
// The unit takes one input item per clock unless its queue is full. In pack
// mode (cfg mode 0) each character's low 7 bits merge with the carried bits
// into packed octets; 8 characters give 7 octets, and an item marked last
// flushes any carry as a final octet. In unpack mode (cfg mode 1) each octet
// gives one character and every seventh octet of a group gives an eighth. An
// item gives zero, one or two results; out_last marks the final result of an
// item marked last. The front forms all results of an item in the cycle it is
// accepted and pushes them as one group into a QUEUE_DEPTH-entry queue; the
// back drains one result per output transfer. A group of two results takes
// an output transfer for each result, so the sustained rate is set by the
// result count at the single output port, and the queue absorbs short bursts
// of two-result items. Input ready drops only when the queue is full. The
// queue registers each group before the back presents it. A config write
// sets mode and clears group position and carry; write it only while idle.
// ----------------------------------------------------------------------------
module gsm_septet_pack_unpack_unit
  import gsp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gsp_cfg_if.sink   cfg_ch,
  gsp_in_if.sink    in_ch,
  gsp_out_if.source out_ch
);

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  gsp_entry_t q_wr_entry;
  gsp_entry_t q_head;

  // Front: accept, classify and hold the group state.
  gsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_wr_entry)
  );

  // Queue: decouple front from a stalled output.
  gsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_wr_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Back: transfer results in order.
  gsp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (q_head),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the GSM septet pack/unpack unit. A driver feeds
// characters or octets from a queue, a predictor works out the octets or
// characters each transfer must cause, and a monitor compares every result
// in order. Both modes run under several flow-control mixes, including a
// long output hold-off that fills the unit and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import gsp_pkg::*;

  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Output hold-off length for the back-pressure phase.
  localparam int HOLDOFF_CYCLES = 80;
  // Settle time after the last expected result; covers items that give no
  // result but may still be in flight inside the unit.
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
  } stream_item_t;

  typedef struct {
    logic [7:0] octet;
    logic       is_last;
  } codec_result_t;

  logic clk;
  logic rst_n;

  gsp_in_if  in_bus ();
  gsp_out_if out_bus ();
  gsp_cfg_if cfg_bus ();

  gsm_septet_pack_unpack_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Items waiting to be offered, and results the unit still owes.
  stream_item_t  items_to_send[$];
  codec_result_t expected_bytes[$];

  // Predictor's copy of the unit's register and state.
  mode_t      cur_mode;
  logic [2:0] grp_pos;
  logic [6:0] carry;

  // Flow-control knobs, set per phase by the sequencer.
  int sender_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int holdoff_left;

  int errors;
  int n_items_sent;
  int n_results_seen;
  int n_mode_writes;
  int quiet_cycles;

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: work out the results of one accepted item and queue them.
  // --------------------------------------------------------------------------
  task automatic predict_codec(input logic [7:0] din, input logic fin);
    logic [7:0]  vals[2];
    logic [15:0] wide;
    logic [7:0]  shifted;
    logic [6:0]  ch;
    int          n;
    n = 0;
    if (cur_mode == MODE_PACK) begin
      // Drop bit 7 of the character; the first character of a group only
      // loads the carry.
      ch = din[6:0];
      if (grp_pos == 3'd0) begin
        carry = ch;
      end else begin
        wide = {9'd0, ch} << (4'd8 - {1'b0, grp_pos});
        vals[n] = wide[7:0] | {1'b0, carry};
        n++;
        carry = ch >> grp_pos;
      end
      grp_pos = grp_pos + 3'd1;
      if (fin) begin
        // Flush a partial group as one more octet; a full group of eight
        // has nothing left over.
        if (grp_pos != 3'd0) begin
          vals[n] = {1'b0, carry};
          n++;
        end
        grp_pos = 3'd0;
        carry   = 7'd0;
      end
    end else begin
      if (grp_pos >= GROUP_OCTETS) begin
        grp_pos = 3'd0;
        carry   = 7'd0;
      end
      wide = {8'd0, din} << grp_pos;
      vals[n] = {1'b0, wide[6:0] | carry};
      n++;
      shifted = din >> (GROUP_OCTETS - grp_pos);
      carry   = shifted[6:0];
      grp_pos = grp_pos + 3'd1;
      // The seventh octet of a group also releases an eighth character.
      if (grp_pos == GROUP_OCTETS) begin
        vals[n] = {1'b0, carry};
        n++;
        grp_pos = 3'd0;
        carry   = 7'd0;
      end
      // Drop a partial remainder at the end of a message.
      if (fin) begin
        grp_pos = 3'd0;
        carry   = 7'd0;
      end
    end
    for (int i = 0; i < n; i++) begin
      expected_bytes.push_back('{octet: vals[i], is_last: fin && (i == n - 1)});
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the front of the pending queue, hold it until the transfer,
  // and insert idle cycles at the phase's rate.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_codec(in_bus.data_byte, in_bus.last);
        void'(items_to_send.pop_front());
        n_items_sent++;
      end
      // Hold an offered item that was not taken; otherwise pick the next.
      if (in_bus.valid && !in_bus.ready) begin
        in_bus.valid <= 1'b1;
      end else if (items_to_send.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= items_to_send[0].data;
        in_bus.last      <= items_to_send[0].is_last;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expectation and
  // drive ready, either at random or held low for a counted hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_results_seen++;
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, got byte %h last %b",
                   $time, out_bus.out_byte, out_bus.out_last);
        end else begin
          if (out_bus.out_byte !== expected_bytes[0].octet ||
              out_bus.out_last !== expected_bytes[0].is_last) begin
            errors++;
            $display("%0t mismatch: expected byte %h last %b, got byte %h last %b",
                     $time, expected_bytes[0].octet, expected_bytes[0].is_last,
                     out_bus.out_byte, out_bus.out_last);
          end
          void'(expected_bytes.pop_front());
        end
      end
      // Start a hold-off when the sequencer asks for one.
      if (hold_request) begin
        hold_request = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no channel moves a transfer for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n ||
        (in_bus.valid && in_bus.ready) ||
        (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles, %0d results still owed",
               $time, quiet_cycles, expected_bytes.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer helpers
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [7:0] d, input logic fin);
    items_to_send.push_back('{data: d, is_last: fin});
  endtask

  // Wait until every item is taken and every result has arrived, then let
  // any zero-result item finish inside the unit.
  task automatic settle();
    while (items_to_send.size() != 0 || in_bus.valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the mode register; the unit clears its group state on the write.
  task automatic write_mode(input mode_t m);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.mode  <= m;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    cur_mode = m;
    grp_pos  = 3'd0;
    carry    = 7'd0;
    n_mode_writes++;
  endtask

  // Queue mostly well-formed messages of random length and content, mixed
  // with short runs of noise where last falls at random.
  task automatic queue_messages(input int count);
    int added;
    int len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++)
          push_item(8'($urandom_range(0, 255)), i == len - 1);
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      added += len;
    end
  endtask

  task automatic set_idling(input int mix);
    case (mix)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 58; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 58; end
      default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value from time zero.
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = 8'h00;
    in_bus.last       = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.mode      = MODE_PACK;
    cur_mode          = MODE_PACK;
    grp_pos           = 3'd0;
    carry             = 7'd0;
    sender_idle_pct   = 0;
    recv_stall_pct    = 0;
    hold_request      = 1'b0;
    holdoff_left      = 0;
    errors            = 0;
    n_items_sent      = 0;
    n_results_seen    = 0;
    n_mode_writes     = 0;
    quiet_cycles      = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pack: one-character messages at the field extremes, a full
    // group of eight that needs no flush (with bit 7 set on some characters
    // to show it is ignored), and a partial group that is flushed.
    set_idling(0);
    write_mode(MODE_PACK);
    push_item(8'h7f, 1'b1);
    push_item(8'h00, 1'b1);
    push_item(8'hff, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h7f, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h55, 1'b0);
    push_item(8'h2a, 1'b0);
    push_item(8'hc1, 1'b0);
    push_item(8'h7f, 1'b1);
    push_item(8'h48, 1'b0);
    push_item(8'he9, 1'b0);
    push_item(8'h21, 1'b1);
    settle();

    // Directed unpack: a full group of seven octets giving the eighth
    // character on the last one, a short message whose remainder is dropped,
    // and a single all-ones octet.
    write_mode(MODE_UNPACK);
    push_item(8'hff, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(8'h5a, 1'b0);
    push_item(8'hfe, 1'b1);
    push_item(8'hc8, 1'b0);
    push_item(8'h32, 1'b0);
    push_item(8'h9b, 1'b1);
    push_item(8'hff, 1'b1);
    settle();

    // Random phases: every flow-control mix in both modes.
    for (int mix = 0; mix < 4; mix++) begin
      for (int m = 0; m < 2; m++) begin
        set_idling(mix);
        write_mode(m == 0 ? MODE_PACK : MODE_UNPACK);
        queue_messages(68);
        settle();
      end
    end

    // Back-pressure: hold the output off while the sender keeps offering,
    // so the internal queue fills and input ready drops.
    set_idling(0);
    write_mode(MODE_PACK);
    hold_request = 1'b1;
    queue_messages(30);
    settle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      errors++;
      $display("%0t %0d expected results never arrived", $time, expected_bytes.size());
    end

    $display("covered %0d input items and %0d results over %0d mode writes,",
             n_items_sent, n_results_seen, n_mode_writes);
    $display("pack and unpack under four flow-control mixes plus an output hold-off");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/gsp_pkg.sv
rtl/core/gsp_stream_if.sv
rtl/core/gsp_front.sv
rtl/core/gsp_queue.sv
rtl/core/gsp_back.sv
rtl/core/gsm_septet_pack_unpack_unit.sv
tb/tb_top.sv
